FILE: hdl/fds_pkg.sv
// Package for the frame delta smoother: widths, constants, register indexes,
// the control state type and the divider request/response structures.
// No dependencies.
`timescale 1ns / 1ps

package fds_pkg;

    // Ring of recent deltas.
    localparam int HIST_DEPTH = 8;
    localparam int POS_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    // Field widths.
    localparam int TS_W     = 40;
    localparam int DELTA_W  = 20;
    localparam int SCALE_W  = 16;
    localparam int SCALED_W = 28;
    localparam int FPS_W    = 24;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    // Derived datapath widths.
    localparam int SUM_W    = DELTA_W + ((HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 0);
    localparam int TALLY_W  = 16;
    localparam int ELAP_W   = DELTA_W + 1;
    localparam int PROD_W   = DELTA_W + SCALE_W;
    localparam int SCALE_FRAC = 8;
    localparam int USEC_W   = 20;
    localparam int NUM_W    = TALLY_W + USEC_W;
    localparam int FPS_FRAC = 8;

    localparam logic [USEC_W-1:0] US_PER_SEC = USEC_W'(1000000);

    // Shared serial divider.
    localparam int DIV_N  = NUM_W + FPS_FRAC;
    localparam int DIV_D  = ELAP_W;
    localparam int STEP_W = $clog2(DIV_N + 1);

    // Configuration register reset values.
    localparam logic [DELTA_W-1:0] MAX_DELTA_RST  = DELTA_W'(250000);
    localparam logic [DELTA_W-1:0] FPS_WINDOW_RST = DELTA_W'(1000000);
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST = SCALE_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DELTA  = 2'd0,
        CFG_FPS_WINDOW = 2'd1,
        CFG_TIME_SCALE = 2'd2,
        CFG_PAUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_SUM,
        S_AVG_GO,
        S_AVG_WAIT,
        S_FPS,
        S_MUL,
        S_FPS_GO,
        S_FPS_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_N-1:0]  dividend;
        logic [DIV_D-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/fds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fds_div.sv
// Restoring serial divider, one quotient bit per cycle, with a step count so
// short dividends placed at the top finish early. Depends on fds_pkg.
`timescale 1ns / 1ps

module fds_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fds_pkg::t_div_req i_req,
    output fds_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic                        n_busy;
    logic                        n_done;
    logic [fds_pkg::STEP_W-1:0]  r_cnt;
    logic [fds_pkg::STEP_W-1:0]  n_cnt;
    logic [fds_pkg::DIV_D-1:0]   r_rem;
    logic [fds_pkg::DIV_D-1:0]   n_rem;
    logic [fds_pkg::DIV_N-1:0]   r_quo;
    logic [fds_pkg::DIV_N-1:0]   n_quo;
    logic [fds_pkg::DIV_D-1:0]   r_div;
    logic [fds_pkg::DIV_D-1:0]   n_div;
    logic [fds_pkg::DIV_D:0]     rem_sh;
    logic [fds_pkg::DIV_D+1:0]   trial;
    logic                        fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[fds_pkg::DIV_N-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_div};
        fits   = !trial[fds_pkg::DIV_D+1];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? trial[fds_pkg::DIV_D-1:0] : rem_sh[fds_pkg::DIV_D-1:0];
            n_quo = {r_quo[fds_pkg::DIV_N-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == fds_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/frame_delta_smoother.sv
// Top level of the frame delta smoother: control sequencer, delta ring in a
// RAM, running sum, fps counter and output register.
// Depends on fds_pkg, fds_ram and fds_div.
`timescale 1ns / 1ps

// Usage
// Input channel: i_valid / o_ready carries one frame timestamp (us) per item.
// Output channel: o_valid / i_ready carries one result item per input item:
// the scaled and unscaled smoothed delta, the current fps in Q16.8 and a flag
// that marks the frame on which fps was recomputed.
// Configuration: a write at index i_cfg_addr with i_cfg_we high updates one
// register in that cycle; writes are expected only while the block is idle.
// Timing: the time from acceptance to the output register is set by the
// shared one-bit-per-cycle divider: 23 steps for the ring average and, on a
// frame that closes an fps window, 44 steps for the fps ratio, plus the ring
// RAM read and the sequencer states around them.
// Flow: one item at a time; a new item is accepted only once the previous
// result is registered and the sequencer is back in idle.
// The output register holds one finished item, so the next input is taken
// while a result still waits; a stalled receiver holds the block only once a
// second result is ready.
// Reset (synchronous, active low) restores the configuration defaults, clears
// the timestamp history, ring position, running sum and fps counters. Ring
// entries are not cleared; their read data is used only after being written.

module frame_delta_smoother (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fds_pkg::TS_W-1:0]      i_timestamp_us,
    // Result items.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fds_pkg::SCALED_W-1:0]  o_scaled_delta_us,
    output logic [fds_pkg::DELTA_W-1:0]   o_unscaled_delta_us,
    output logic [fds_pkg::FPS_W-1:0]     o_fps_q8,
    output logic                          o_fps_updated,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [fds_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [fds_pkg::CFG_W-1:0]     i_cfg_wdata
);

    fds_pkg::t_state r_state;
    fds_pkg::t_state n_state;

    // Configuration.
    logic [fds_pkg::DELTA_W-1:0] r_max_delta, n_max_delta;
    logic [fds_pkg::DELTA_W-1:0] r_fps_window, n_fps_window;
    logic [fds_pkg::SCALE_W-1:0] r_time_scale, n_time_scale;
    logic                        r_paused, n_paused;

    // Architectural state held in registers.
    logic [fds_pkg::TS_W-1:0]    r_last, n_last;
    logic [fds_pkg::POS_W-1:0]   r_wpos, n_wpos;
    logic                        r_full, n_full;
    logic [fds_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [fds_pkg::TALLY_W-1:0] r_tally, n_tally;
    logic [fds_pkg::ELAP_W-1:0]  r_elapsed, n_elapsed;
    logic [fds_pkg::FPS_W-1:0]   r_fps, n_fps;

    // Per-item working registers.
    logic [fds_pkg::TS_W-1:0]     r_ts, n_ts;
    logic [fds_pkg::DELTA_W-1:0]  r_delta, n_delta;
    logic [fds_pkg::DELTA_W-1:0]  r_avg, n_avg;
    logic [fds_pkg::SCALED_W-1:0] r_scaled, n_scaled;
    logic [fds_pkg::NUM_W-1:0]    r_num, n_num;
    logic                         r_upd, n_upd;

    // Output register.
    logic                         r_out_valid, n_out_valid;
    logic [fds_pkg::SCALED_W-1:0] r_out_scaled, n_out_scaled;
    logic [fds_pkg::DELTA_W-1:0]  r_out_avg, n_out_avg;
    logic [fds_pkg::FPS_W-1:0]    r_out_fps, n_out_fps;
    logic                         r_out_upd, n_out_upd;

    // Ring RAM access.
    logic                        ram_we;
    logic                        ram_re;
    logic [fds_pkg::DELTA_W-1:0] ram_rdata;

    fds_pkg::t_div_req div_req;
    fds_pkg::t_div_rsp div_rsp;

    // Combinational datapath terms.
    logic [fds_pkg::TS_W:0]      ts_diff;
    logic [fds_pkg::TS_W-1:0]    raw;
    logic [fds_pkg::POS_W-1:0]   pos_next;
    logic [fds_pkg::CNT_W-1:0]   count;
    logic [fds_pkg::ELAP_W-1:0]  elapsed_sum;
    logic [fds_pkg::DELTA_W-1:0] window;
    logic                        trig;
    logic [fds_pkg::PROD_W-1:0]  prod;

    fds_ram #(
        .WIDTH (fds_pkg::DELTA_W),
        .DEPTH (fds_pkg::HIST_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (r_delta),
        .i_re    (ram_re),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    fds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared arithmetic terms; each is used in exactly one sequencer state.
    always_comb begin
        ts_diff  = {1'b0, r_ts} - {1'b0, r_last};
        raw      = ts_diff[fds_pkg::TS_W] ? '0 : ts_diff[fds_pkg::TS_W-1:0];
        pos_next = (r_wpos == fds_pkg::POS_W'(fds_pkg::HIST_DEPTH - 1)) ?
                   '0 : r_wpos + 1'b1;
        count    = r_full ? fds_pkg::CNT_W'(fds_pkg::HIST_DEPTH) :
                   fds_pkg::CNT_W'(r_wpos);
        elapsed_sum = r_elapsed + fds_pkg::ELAP_W'(r_avg);
        window   = (r_fps_window == '0) ? fds_pkg::DELTA_W'(1) : r_fps_window;
        trig     = elapsed_sum >= fds_pkg::ELAP_W'(window);
        prod     = fds_pkg::PROD_W'(r_avg) * fds_pkg::PROD_W'(r_time_scale);
    end

    // Sequencer: next state, datapath updates and configuration writes.
    always_comb begin
        n_state      = r_state;
        n_max_delta  = r_max_delta;
        n_fps_window = r_fps_window;
        n_time_scale = r_time_scale;
        n_paused     = r_paused;
        n_last       = r_last;
        n_wpos       = r_wpos;
        n_full       = r_full;
        n_sum        = r_sum;
        n_tally      = r_tally;
        n_elapsed    = r_elapsed;
        n_fps        = r_fps;
        n_ts         = r_ts;
        n_delta      = r_delta;
        n_avg        = r_avg;
        n_scaled     = r_scaled;
        n_num        = r_num;
        n_upd        = r_upd;
        n_out_valid  = r_out_valid;
        n_out_scaled = r_out_scaled;
        n_out_avg    = r_out_avg;
        n_out_fps    = r_out_fps;
        n_out_upd    = r_out_upd;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        div_req      = '0;

        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            fds_pkg::S_IDLE: begin
                // The old ring entry at the write position is fetched now so
                // it is ready when the running sum is updated.
                if (i_valid) begin
                    n_ts    = i_timestamp_us;
                    ram_re  = 1'b1;
                    n_state = fds_pkg::S_DELTA;
                end
            end
            fds_pkg::S_DELTA: begin
                // Backward timestamps give zero; the clamp caps the rest.
                n_delta = (raw > fds_pkg::TS_W'(r_max_delta)) ?
                          r_max_delta : raw[fds_pkg::DELTA_W-1:0];
                n_last  = r_ts;
                n_state = fds_pkg::S_SUM;
            end
            fds_pkg::S_SUM: begin
                ram_we = 1'b1;
                n_sum  = r_sum - (r_full ? fds_pkg::SUM_W'(ram_rdata) : '0)
                         + fds_pkg::SUM_W'(r_delta);
                n_wpos = pos_next;
                if (pos_next == '0) begin
                    n_full = 1'b1;
                end
                n_state = fds_pkg::S_AVG_GO;
            end
            fds_pkg::S_AVG_GO: begin
                // The sum goes to the top of the dividend so that only its
                // own width of steps is needed.
                div_req.start    = 1'b1;
                div_req.dividend = {r_sum, {(fds_pkg::DIV_N - fds_pkg::SUM_W){1'b0}}};
                div_req.divisor  = fds_pkg::DIV_D'(count);
                div_req.steps    = fds_pkg::STEP_W'(fds_pkg::SUM_W);
                n_state          = fds_pkg::S_AVG_WAIT;
            end
            fds_pkg::S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    n_avg   = div_rsp.quotient[fds_pkg::DELTA_W-1:0];
                    n_state = fds_pkg::S_FPS;
                end
            end
            fds_pkg::S_FPS: begin
                if (r_tally != '1) begin
                    n_tally = r_tally + 1'b1;
                end
                n_elapsed = elapsed_sum;
                n_upd     = trig;
                n_scaled  = r_paused ? '0 :
                            prod[fds_pkg::SCALE_FRAC +: fds_pkg::SCALED_W];
                n_state   = trig ? fds_pkg::S_MUL : fds_pkg::S_DONE;
            end
            fds_pkg::S_MUL: begin
                n_num   = fds_pkg::NUM_W'(r_tally) * fds_pkg::NUM_W'(fds_pkg::US_PER_SEC);
                n_state = fds_pkg::S_FPS_GO;
            end
            fds_pkg::S_FPS_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_num, {fds_pkg::FPS_FRAC{1'b0}}};
                div_req.divisor  = r_elapsed;
                div_req.steps    = fds_pkg::STEP_W'(fds_pkg::DIV_N);
                n_state          = fds_pkg::S_FPS_WAIT;
            end
            fds_pkg::S_FPS_WAIT: begin
                if (div_rsp.done) begin
                    n_fps = (|div_rsp.quotient[fds_pkg::DIV_N-1:fds_pkg::FPS_W]) ?
                            '1 : div_rsp.quotient[fds_pkg::FPS_W-1:0];
                    n_tally   = '0;
                    n_elapsed = '0;
                    n_state   = fds_pkg::S_DONE;
                end
            end
            fds_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_scaled = r_scaled;
                    n_out_avg    = r_avg;
                    n_out_fps    = r_fps;
                    n_out_upd    = r_upd;
                    n_state      = fds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fds_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (fds_pkg::t_cfg_idx'(i_cfg_addr))
                fds_pkg::CFG_MAX_DELTA:  n_max_delta  = i_cfg_wdata[fds_pkg::DELTA_W-1:0];
                fds_pkg::CFG_FPS_WINDOW: n_fps_window = i_cfg_wdata[fds_pkg::DELTA_W-1:0];
                fds_pkg::CFG_TIME_SCALE: n_time_scale = i_cfg_wdata[fds_pkg::SCALE_W-1:0];
                fds_pkg::CFG_PAUSED:     n_paused     = i_cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delta  <= fds_pkg::MAX_DELTA_RST;
            r_fps_window <= fds_pkg::FPS_WINDOW_RST;
            r_time_scale <= fds_pkg::TIME_SCALE_RST;
            r_paused     <= 1'b0;
            r_last       <= '0;
            r_wpos       <= '0;
            r_full       <= 1'b0;
            r_sum        <= '0;
            r_tally      <= '0;
            r_elapsed    <= '0;
            r_fps        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_max_delta  <= n_max_delta;
            r_fps_window <= n_fps_window;
            r_time_scale <= n_time_scale;
            r_paused     <= n_paused;
            r_last       <= n_last;
            r_wpos       <= n_wpos;
            r_full       <= n_full;
            r_sum        <= n_sum;
            r_tally      <= n_tally;
            r_elapsed    <= n_elapsed;
            r_fps        <= n_fps;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts         <= n_ts;
        r_delta      <= n_delta;
        r_avg        <= n_avg;
        r_scaled     <= n_scaled;
        r_num        <= n_num;
        r_upd        <= n_upd;
        r_out_scaled <= n_out_scaled;
        r_out_avg    <= n_out_avg;
        r_out_fps    <= n_out_fps;
        r_out_upd    <= n_out_upd;
    end

    assign o_ready             = (r_state == fds_pkg::S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_scaled_delta_us   = r_out_scaled;
    assign o_unscaled_delta_us = r_out_avg;
    assign o_fps_q8            = r_out_fps;
    assign o_fps_updated       = r_out_upd;

    // The divider is never left running when a new item may enter.
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !div_rsp.busy)
        else $error("divider busy while accepting items");

    // A divider result only arrives in a state that consumes it.
    a_done_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == fds_pkg::S_AVG_WAIT ||
                          r_state == fds_pkg::S_FPS_WAIT))
        else $error("divider result arrived outside a wait state");

    // The output register is only loaded from the final sequencer state.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == fds_pkg::S_DONE))
        else $error("output loaded outside the done state");

    // Closing an fps window clears both counters.
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fds_pkg::S_FPS_WAIT && div_rsp.done)
        |=> (r_tally == '0 && r_elapsed == '0))
        else $error("fps counters not cleared after update");

endmodule
